>>> rtl/ste_pkg.sv
`default_nettype none

package ste_pkg;

    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_PIECE = 1'b1;

    localparam logic [1:0] DPLC_NONE = 2'd0;
    localparam logic [1:0] DPLC_ONE  = 2'd1;
    localparam logic [1:0] DPLC_MANY = 2'd2;

    localparam int ATTR_PAL_LO = 13;
    localparam int ATTR_HFLIP  = 11;
    localparam int ATTR_VFLIP  = 12;
    localparam int TILE_SHIFT  = 3;

    typedef enum logic [0:0] {
        WALK_IDLE,
        WALK_EMIT
    } walk_state_t;

    typedef struct packed {
        logic        action;
        logic [7:0]  entry_count;
        logic [15:0] dplc_word;
        logic [11:0] x_origin;
        logic [11:0] y_origin;
        logic [3:0]  palette_base;
        logic [7:0]  piece_y;
        logic [3:0]  size_code;
        logic [15:0] attr_word;
        logic [7:0]  piece_x;
    } in_t;

    typedef struct packed {
        logic [12:0] tile_index;
        logic        tile_valid;
        logic [12:0] pos_x;
        logic [12:0] pos_y;
        logic [4:0]  palette;
        logic [1:0]  flip_flags;
        logic        last;
    } out_t;

    // Everything about the piece that stays fixed while its tiles are walked.
    typedef struct packed {
        logic [12:0] left;
        logic [12:0] top;
        logic [11:0] base;
        logic        valid;
        logic [4:0]  palette;
        logic [1:0]  flags;
        logic [1:0]  cols_m1;
        logic [1:0]  rows_m1;
    } ctx_t;

    typedef struct packed {
        logic       busy;
        logic       emit;
        logic [1:0] col;
        logic [1:0] row;
        logic [3:0] n;
        logic       last;
    } walk_t;

endpackage

`default_nettype wire

>>> rtl/ste_walk.sv
`default_nettype none

module ste_walk
    import ste_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       start,
    input  wire logic       hold,
    input  wire logic [1:0] cols_m1,
    input  wire logic [1:0] rows_m1,
    input  wire logic [1:0] flags,
    output walk_t           walk
);

    walk_state_t state_reg, state_next;
    logic [1:0]  c_reg, c_next;
    logic [1:0]  r_reg, r_next;
    logic [3:0]  n_reg, n_next;
    logic        emit;
    logic        at_end;

    assign emit   = (state_reg == WALK_EMIT) && !hold;
    assign at_end = (c_reg == cols_m1) && (r_reg == rows_m1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            WALK_IDLE: begin
                if (start) begin
                    state_next = WALK_EMIT;
                end
            end
            WALK_EMIT: begin
                if (emit && at_end) begin
                    state_next = WALK_IDLE;
                end
            end
            default: state_next = WALK_IDLE;
        endcase
    end

    always_comb begin
        walk.busy = (state_reg != WALK_IDLE);
        walk.emit = emit;
        // Flips reverse the visiting order but not the tile numbering.
        walk.col  = flags[0] ? (cols_m1 - c_reg) : c_reg;
        walk.row  = flags[1] ? (rows_m1 - r_reg) : r_reg;
        walk.n    = n_reg;
        walk.last = at_end;
    end

    always_comb begin
        c_next = c_reg;
        r_next = r_reg;
        n_next = n_reg;
        if (start) begin
            c_next = 2'd0;
            r_next = 2'd0;
            n_next = 4'd0;
        end else if (emit) begin
            n_next = n_reg + 4'd1;
            if (r_reg == rows_m1) begin
                r_next = 2'd0;
                c_next = c_reg + 2'd1;
            end else begin
                r_next = r_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= WALK_IDLE;
            c_reg     <= 2'd0;
            r_reg     <= 2'd0;
            n_reg     <= 4'd0;
        end else begin
            state_reg <= state_next;
            c_reg     <= c_next;
            r_reg     <= r_next;
            n_reg     <= n_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ste_place.sv
`default_nettype none

module ste_place
    import ste_pkg::*;
(
    input  wire ctx_t  ctx,
    input  wire walk_t walk,
    output out_t       tile
);

    logic [12:0] col_off;
    logic [12:0] row_off;

    assign col_off = {8'd0, walk.col, {TILE_SHIFT{1'b0}}};
    assign row_off = {8'd0, walk.row, {TILE_SHIFT{1'b0}}};

    always_comb begin
        tile.tile_index = ctx.valid ? ({1'b0, ctx.base} + {9'd0, walk.n}) : 13'd0;
        tile.tile_valid = ctx.valid;
        tile.pos_x      = ctx.left + col_off;
        tile.pos_y      = ctx.top + row_off;
        tile.palette    = ctx.palette;
        tile.flip_flags = ctx.flags;
        tile.last       = walk.last;
    end

endmodule

`default_nettype wire

>>> rtl/sprite_mapping_tile_expander.sv
// Sprite mapping tile expander.
// Input channel s_*: a begin beat (action 0) latches the sprite origin, palette
// base, DPLC entry count and fixed DPLC word; it yields no output. A piece beat
// (action 1) is expanded into one 8x8 tile placement per tile of the piece,
// column by column, rows within a column, with the tile index rising by one.
// Output channel m_*: one beat per tile; last marks the final tile of a piece.
// Flow: a begin beat does not block the input. A piece beat keeps s_ready low
// until the column/row walker, which places one tile per cycle while m_ready
// does not stall it, has issued its last tile. The first tile reaches m_data
// through the walker state register and then the result register.
// Stall: the result register holds its beat while m_ready is low and the
// walker pauses; no tile is dropped or repeated.
// Reset: aresetn is synchronous, active low. It clears the sprite state to no
// DPLC entries, so pieces seen before any begin beat give invalid tiles with
// tile index zero.
`default_nettype none

module sprite_mapping_tile_expander
    import ste_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic [1:0]  dplc_mode_reg, dplc_mode_next;
    logic [11:0] fixed_tile_reg, fixed_tile_next;
    logic [11:0] origin_x_reg, origin_x_next;
    logic [11:0] origin_y_reg, origin_y_next;
    logic [3:0]  pal_base_reg, pal_base_next;
    ctx_t        ctx_reg, ctx_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    walk_t       walk;
    out_t        tile;
    logic        accept;
    logic        start;
    logic        hold;

    assign s_ready = !walk.busy;
    assign accept  = s_valid && s_ready;
    assign start   = accept && (s_data.action == ACT_PIECE);
    assign hold    = m_valid_reg && !m_ready;

    ste_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .hold    (hold),
        .cols_m1 (ctx_reg.cols_m1),
        .rows_m1 (ctx_reg.rows_m1),
        .flags   (ctx_reg.flags),
        .walk    (walk)
    );

    ste_place u_place (
        .ctx  (ctx_reg),
        .walk (walk),
        .tile (tile)
    );

    always_comb begin
        dplc_mode_next  = dplc_mode_reg;
        fixed_tile_next = fixed_tile_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        pal_base_next   = pal_base_reg;
        if (accept && (s_data.action == ACT_BEGIN)) begin
            if (s_data.entry_count == 8'd0) begin
                dplc_mode_next = DPLC_NONE;
            end else if (s_data.entry_count == 8'd1) begin
                dplc_mode_next = DPLC_ONE;
            end else begin
                dplc_mode_next = DPLC_MANY;
            end
            fixed_tile_next = s_data.dplc_word[11:0];
            origin_x_next   = s_data.x_origin;
            origin_y_next   = s_data.y_origin;
            pal_base_next   = s_data.palette_base;
        end
    end

    always_comb begin
        ctx_next = ctx_reg;
        if (start) begin
            ctx_next.left    = {origin_x_reg[11], origin_x_reg}
                             + {{5{s_data.piece_x[7]}}, s_data.piece_x};
            ctx_next.top     = {origin_y_reg[11], origin_y_reg}
                             + {{5{s_data.piece_y[7]}}, s_data.piece_y};
            ctx_next.base    = (dplc_mode_reg == DPLC_MANY) ? s_data.dplc_word[11:0]
                                                            : fixed_tile_reg;
            ctx_next.valid   = (dplc_mode_reg != DPLC_NONE);
            ctx_next.palette = {3'd0, s_data.attr_word[ATTR_PAL_LO+1:ATTR_PAL_LO]}
                             + {1'b0, pal_base_reg};
            ctx_next.flags   = {s_data.attr_word[ATTR_VFLIP], s_data.attr_word[ATTR_HFLIP]};
            ctx_next.cols_m1 = s_data.size_code[3:2];
            ctx_next.rows_m1 = s_data.size_code[1:0];
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (walk.emit) begin
            m_data_next  = tile;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dplc_mode_reg  <= DPLC_NONE;
            fixed_tile_reg <= 12'd0;
            origin_x_reg   <= 12'd0;
            origin_y_reg   <= 12'd0;
            pal_base_reg   <= 4'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            dplc_mode_reg  <= dplc_mode_next;
            fixed_tile_reg <= fixed_tile_next;
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            pal_base_reg   <= pal_base_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctx_reg    <= ctx_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A piece beat always occupies the walker in the following cycle.
    a_piece_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("piece accepted but input still ready");

    // After the final tile of a piece is issued, the input reopens.
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (walk.emit && walk.last) |=> s_ready)
        else $error("walker still busy after final tile");

    // Invalid tiles always carry tile index zero.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.tile_valid || (m_data.tile_index == 13'd0)))
        else $error("invalid tile with nonzero index");

    // The walker never issues a tile into a stalled result register.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !walk.emit)
        else $error("tile issued while output stalled");

endmodule

`default_nettype wire
